@@ hdl/tli_pkg.sv @@
`timescale 1ns / 1ps

package tli_pkg;

	localparam int MAX_LINES = 1024;
	localparam int MAX_CHARS = 65536;

	localparam int LINE_AW = $clog2(MAX_LINES);
	localparam int LCNT_W  = LINE_AW + 1;
	localparam int CHAR_W  = 17;
	localparam int OFF_W   = 16;
	localparam int LEN_W   = 17;

	localparam logic [7:0] CH_LF = 8'd10;
	localparam logic [7:0] CH_CR = 8'd13;

	typedef enum logic [1:0] {
		OP_BYTE  = 2'd0,
		OP_END   = 2'd1,
		OP_FIND  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		END_NONE = 2'd0,
		END_LF   = 2'd1,
		END_CR   = 2'd2,
		END_CRLF = 2'd3
	} ending_t;

	typedef struct packed {
		logic [OFF_W-1:0] start;
		logic [LEN_W-1:0] len;
		logic [LEN_W-1:0] text;
		ending_t          kind;
	} line_entry_t;

	typedef struct packed {
		logic               we;
		logic [LINE_AW-1:0] addr;
		line_entry_t        data;
	} tbl_wr_t;

	typedef struct packed {
		logic               re;
		logic [LINE_AW-1:0] addr;
	} tbl_rd_t;

	typedef struct packed {
		logic               line_done;
		logic               found;
		logic [LINE_AW-1:0] line_number;
		logic [OFF_W-1:0]   rel;
		line_entry_t        entry;
	} result_t;

endpackage

@@ hdl/tli_line_table.sv @@
`timescale 1ns / 1ps

module tli_line_table import tli_pkg::*; (
	input  logic        clk,
	input  tbl_wr_t     wr,
	input  tbl_rd_t     rd,
	output line_entry_t rdata
);

	line_entry_t mem [MAX_LINES];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.re) begin
			rdata <= mem[rd.addr];
		end
	end

endmodule

@@ hdl/tli_scanner.sv @@
`timescale 1ns / 1ps

module tli_scanner import tli_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  op_t               op,
	input  logic [7:0]        text_byte,
	output tbl_wr_t           wr,
	output logic              vld_q,
	output result_t           res_q,
	output logic [LCNT_W-1:0] stored_q,
	output logic [CHAR_W-1:0] seen_q,
	output logic              dropped_q
);

	logic [CHAR_W-1:0] run_q;
	logic              cr_q;

	logic [LCNT_W-1:0] stored_d;
	logic [CHAR_W-1:0] seen_d, run_d;
	logic              cr_d, dropped_d;
	logic              line_vld, tbl_full, is_lf, is_cr;
	logic [CHAR_W-1:0] ln_start;
	logic [LEN_W-1:0]  ln_len;
	ending_t           ln_kind;
	result_t           res_d;

	assign is_lf    = (text_byte == CH_LF);
	assign is_cr    = (text_byte == CH_CR);
	assign tbl_full = (stored_q >= LCNT_W'(MAX_LINES));

	always_comb begin
		stored_d  = stored_q;
		seen_d    = seen_q;
		run_d     = run_q;
		cr_d      = cr_q;
		dropped_d = dropped_q;
		line_vld  = 1'b0;
		ln_start  = '0;
		ln_len    = '0;
		ln_kind   = END_NONE;
		case (op)
			OP_BYTE: begin
				if (seen_q >= CHAR_W'(MAX_CHARS)) begin
					dropped_d = 1'b1;
				end else begin
					seen_d = seen_q + 1'b1;
					if (cr_q) begin
						// close the CR line; an LF here joins it as CRLF
						line_vld = 1'b1;
						ln_start = seen_q - run_q - 1'b1;
						ln_len   = is_lf ? run_q + 2'd2 : run_q + 1'b1;
						ln_kind  = is_lf ? END_CRLF : END_CR;
						run_d    = (is_lf || is_cr) ? '0 : CHAR_W'(1);
						cr_d     = is_cr;
					end else if (is_lf) begin
						line_vld = 1'b1;
						ln_start = seen_q - run_q;
						ln_len   = run_q + 1'b1;
						ln_kind  = END_LF;
						run_d    = '0;
					end else if (is_cr) begin
						cr_d = 1'b1;
					end else begin
						run_d = run_q + 1'b1;
					end
				end
			end
			OP_END: begin
				if (cr_q) begin
					line_vld = 1'b1;
					ln_start = seen_q - run_q - 1'b1;
					ln_len   = run_q + 1'b1;
					ln_kind  = END_CR;
				end else if (run_q != '0) begin
					line_vld = 1'b1;
					ln_start = seen_q - run_q;
					ln_len   = run_q;
					ln_kind  = END_NONE;
				end
				run_d = '0;
				cr_d  = 1'b0;
			end
			OP_CLEAR: begin
				stored_d  = '0;
				seen_d    = '0;
				run_d     = '0;
				cr_d      = 1'b0;
				dropped_d = 1'b0;
			end
			default: begin
			end
		endcase

		wr.we         = go && line_vld && !tbl_full;
		wr.addr       = stored_q[LINE_AW-1:0];
		wr.data.start = ln_start[OFF_W-1:0];
		wr.data.len   = ln_len;
		wr.data.text  = run_q;
		wr.data.kind  = ln_kind;

		res_d = '0;
		if (line_vld) begin
			if (tbl_full) begin
				dropped_d = 1'b1;
			end else begin
				stored_d          = stored_q + 1'b1;
				res_d.line_done   = 1'b1;
				res_d.line_number = stored_q[LINE_AW-1:0];
				res_d.entry       = wr.data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_q  <= '0;
			seen_q    <= '0;
			run_q     <= '0;
			cr_q      <= 1'b0;
			dropped_q <= 1'b0;
			vld_q     <= 1'b0;
		end else begin
			vld_q <= go;
			if (go) begin
				stored_q  <= stored_d;
				seen_q    <= seen_d;
				run_q     <= run_d;
				cr_q      <= cr_d;
				dropped_q <= dropped_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			res_q <= res_d;
		end
	end

endmodule

@@ hdl/tli_search.sv @@
`timescale 1ns / 1ps

module tli_search import tli_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [OFF_W-1:0]  query,
	input  logic [LCNT_W-1:0] line_count,
	output tbl_rd_t           rd,
	input  line_entry_t       rdata,
	output logic              busy,
	output logic              vld_q,
	output result_t           res_q
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_ADDR = 4'b0010,
		S_CMP  = 4'b0100,
		S_LAST = 4'b1000
	} srch_state_t;

	srch_state_t        state_q;
	logic [LINE_AW-1:0] lo_q, hi_q, mid_q;
	logic [OFF_W-1:0]   q_q;

	logic [LCNT_W-1:0]  span, mid_w;
	logic [LINE_AW-1:0] mid;
	logic               narrow;
	logic [OFF_W+1:0]   end_pos;
	logic               hit;
	result_t            last_res;

	assign narrow  = (lo_q < hi_q);
	assign span    = {1'b0, hi_q} - {1'b0, lo_q} + 1'b1;
	assign mid_w   = {1'b0, lo_q} + (span >> 1);
	assign mid     = mid_w[LINE_AW-1:0];
	assign rd.re   = (state_q == S_ADDR);
	assign rd.addr = narrow ? mid : lo_q;
	assign busy    = (state_q != S_IDLE);

	assign end_pos = {2'b00, rdata.start} + {1'b0, rdata.len};
	assign hit     = (q_q >= rdata.start) && ({2'b00, q_q} < end_pos);

	always_comb begin
		last_res = '0;
		if (hit) begin
			last_res.found       = 1'b1;
			last_res.line_number = lo_q;
			last_res.rel         = q_q - rdata.start;
			last_res.entry       = rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vld_q   <= 1'b0;
		end else begin
			// strobe on an empty-table find or once the last entry is in
			vld_q <= (state_q == S_LAST) ||
					((state_q == S_IDLE) && go && (line_count == '0));
			case (state_q)
				S_IDLE: begin
					if (go && (line_count != '0)) begin
						state_q <= S_ADDR;
					end
				end
				S_ADDR: state_q <= narrow ? S_CMP : S_LAST;
				S_CMP:  state_q <= S_ADDR;
				S_LAST: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (go) begin
					lo_q  <= '0;
					hi_q  <= LINE_AW'(line_count - 1'b1);
					q_q   <= query;
					res_q <= '0;
				end
			end
			S_ADDR: mid_q <= mid;
			S_CMP: begin
				if (rdata.start <= q_q) begin
					lo_q <= mid_q;
				end else begin
					hi_q <= mid_q - 1'b1;
				end
			end
			S_LAST: res_q <= last_res;
			default: begin
			end
		endcase
	end

	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (lo_q <= hi_q))
		else $error("search window inverted");

	a_cmp_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> ($past(state_q) == S_ADDR))
		else $error("compare without a preceding table read");

	a_window_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> ({1'b0, hi_q} < line_count))
		else $error("search reaches past stored lines");

	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q |-> (state_q == S_IDLE))
		else $error("search result while still searching");

endmodule

@@ hdl/text_line_indexer_top.sv @@
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// request   start, accepted when   op, text_byte, query_offset
//           busy is low
// result    done, one cycle,       line_done, found, line_number, line_start,
//           cannot be held off     relative_offset, line_length, text_length,
//                                  ending_kind, line_count, char_count, overflow
//
// Byte, end-of-text and clear requests leave busy low, so while no search is
// running one may be issued every cycle; the result strobes on the following
// cycle. A find request holds busy while the search runs and its result
// strobes in the first cycle with busy low again; with no stored line busy
// stays low and the result follows on the next cycle.
// Each step of the binary search is one read of the line table's single
// registered port followed by one compare. The receiver cannot stall.
// Reset clears the counters and flags only; the line table needs no clearing
// pass, as only entries below the line count are ever read.

module text_line_indexer_top import tli_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         op,
	input  logic [7:0]         text_byte,
	input  logic [OFF_W-1:0]   query_offset,
	output logic               done,
	output logic               line_done,
	output logic               found,
	output logic [LINE_AW-1:0] line_number,
	output logic [OFF_W-1:0]   line_start,
	output logic [OFF_W-1:0]   relative_offset,
	output logic [LEN_W-1:0]   line_length,
	output logic [LEN_W-1:0]   text_length,
	output logic [1:0]         ending_kind,
	output logic [LCNT_W-1:0]  line_count,
	output logic [CHAR_W-1:0]  char_count,
	output logic               overflow
);

	op_t         op_in;
	logic        accept, scan_go, find_go;
	tbl_wr_t     tbl_wr;
	tbl_rd_t     tbl_rd;
	line_entry_t tbl_rdata;
	logic        scan_vld, srch_vld;
	result_t     scan_res, srch_res, res;

	// take a request only while no search is running
	assign op_in   = op_t'(op);
	assign accept  = start && !busy;
	assign find_go = accept && (op_in == OP_FIND);
	assign scan_go = accept && (op_in != OP_FIND);

	tli_line_table u_table (
		.clk   (clk),
		.wr    (tbl_wr),
		.rd    (tbl_rd),
		.rdata (tbl_rdata)
	);

	// the scanner writes only on an accepted request, the search reads only
	// while busy, so table accesses never overlap
	tli_scanner u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (scan_go),
		.op        (op_in),
		.text_byte (text_byte),
		.wr        (tbl_wr),
		.vld_q     (scan_vld),
		.res_q     (scan_res),
		.stored_q  (line_count),
		.seen_q    (char_count),
		.dropped_q (overflow)
	);

	tli_search u_search (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (find_go),
		.query      (query_offset),
		.line_count (line_count),
		.rd         (tbl_rd),
		.rdata      (tbl_rdata),
		.busy       (busy),
		.vld_q      (srch_vld),
		.res_q      (srch_res)
	);

	// select whichever unit finished; counts are already the post-request values
	assign res             = srch_vld ? srch_res : scan_res;
	assign done            = scan_vld || srch_vld;
	assign line_done       = res.line_done;
	assign found           = res.found;
	assign line_number     = res.line_number;
	assign line_start      = res.entry.start;
	assign relative_offset = res.rel;
	assign line_length     = res.entry.len;
	assign text_length     = res.entry.text;
	assign ending_kind     = res.entry.kind;

	a_one_source: assert property (@(posedge clk) disable iff (!arst_n)
		!(scan_vld && srch_vld))
		else $error("scanner and search report in the same cycle");

	a_no_write_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !tbl_wr.we)
		else $error("line table written during a search");

	a_done_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(accept) || $past(busy)))
		else $error("result strobe with no request behind it");

endmodule

@@ tb/text_line_indexer_top_test.sv @@
`timescale 1ns / 1ps

module text_line_indexer_top_test;
	import tli_pkg::*;

	// Allow this many cycles with no request and no result before giving up.
	// The longest honest stretch is a sender idle run or a full-table find.
	localparam int STALL_LIMIT = 1000;
	// After the last result, idle out for END_IDLE before finishing.
	localparam int END_IDLE    = 40;

	// One request as the sender queues it: payload plus pacing controls.
	typedef struct {
		op_t              op;
		logic [7:0]       ch;
		logic [OFF_W-1:0] q;
		int               idle_pct;
		bit               drain;
	} text_req_t;

	// One result, laid out field by field at the port widths.
	typedef struct packed {
		logic               line_done;
		logic               found;
		logic [LINE_AW-1:0] line_number;
		logic [OFF_W-1:0]   line_start;
		logic [OFF_W-1:0]   rel;
		logic [LEN_W-1:0]   line_length;
		logic [LEN_W-1:0]   text_length;
		ending_t            kind;
		logic [LCNT_W-1:0]  line_count;
		logic [CHAR_W-1:0]  char_count;
		logic               overflow;
	} index_result_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [1:0]         op = OP_BYTE;
	logic [7:0]         text_byte = '0;
	logic [OFF_W-1:0]   query_offset = '0;
	logic               busy;
	logic               done;
	logic               line_done;
	logic               found;
	logic [LINE_AW-1:0] line_number;
	logic [OFF_W-1:0]   line_start;
	logic [OFF_W-1:0]   relative_offset;
	logic [LEN_W-1:0]   line_length;
	logic [LEN_W-1:0]   text_length;
	logic [1:0]         ending_kind;
	logic [LCNT_W-1:0]  line_count;
	logic [CHAR_W-1:0]  char_count;
	logic               overflow;

	text_line_indexer_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.op              (op),
		.text_byte       (text_byte),
		.query_offset    (query_offset),
		.done            (done),
		.line_done       (line_done),
		.found           (found),
		.line_number     (line_number),
		.line_start      (line_start),
		.relative_offset (relative_offset),
		.line_length     (line_length),
		.text_length     (text_length),
		.ending_kind     (ending_kind),
		.line_count      (line_count),
		.char_count      (char_count),
		.overflow        (overflow)
	);

	text_req_t     request_queue[$];
	index_result_t awaited_results[$];
	text_req_t     in_flight;
	int            failures = 0;
	// Results still owed by the block, kept by the driver alone.
	int            owed = 0;

	// Shadow copy of the line table and the scanner state.
	logic [OFF_W-1:0] tbl_start [MAX_LINES];
	logic [LEN_W-1:0] tbl_len   [MAX_LINES];
	logic [LEN_W-1:0] tbl_text  [MAX_LINES];
	ending_t          tbl_kind  [MAX_LINES];
	int               n_lines = 0;
	int               n_bytes = 0;
	int               run_len = 0;
	bit               cr_wait = 1'b0;
	bit               dropped = 1'b0;

	// Generator bookkeeping: pacing for the next request and bytes since clear.
	int gen_idle  = 0;
	bit gen_drain = 1'b0;
	int gen_bytes = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Line indexing, mirrored in the testbench
	// ------------------------------------------------------------------

	// Record a finished line, or drop it and raise the overflow flag when the
	// table is already full.
	function automatic void store_line(input int st, input int len, input int txt,
			input ending_t kind, inout index_result_t r);
		if (n_lines >= MAX_LINES) begin
			dropped = 1'b1;
		end else begin
			tbl_start[n_lines] = st[OFF_W-1:0];
			tbl_len[n_lines]   = len[LEN_W-1:0];
			tbl_text[n_lines]  = txt[LEN_W-1:0];
			tbl_kind[n_lines]  = kind;
			r.line_done   = 1'b1;
			r.line_number = n_lines[LINE_AW-1:0];
			r.line_start  = st[OFF_W-1:0];
			r.rel         = '0;
			r.line_length = len[LEN_W-1:0];
			r.text_length = txt[LEN_W-1:0];
			r.kind        = kind;
			n_lines++;
		end
	endfunction

	function automatic index_result_t predict_request(input op_t rop, input logic [7:0] ch,
			input logic [OFF_W-1:0] q);
		index_result_t r;
		int            pos;
		int            lo;
		int            hi;
		int            mid;
		bit            consumed;
		r = '0;
		case (rop)
			OP_BYTE: begin
				if (n_bytes >= MAX_CHARS) begin
					// Past the character limit: ignore the byte, keep any CR pending.
					dropped = 1'b1;
				end else begin
					pos = n_bytes;
					n_bytes++;
					consumed = 1'b0;
					if (cr_wait) begin
						// The CR sat just before this byte; an LF makes it a CRLF.
						cr_wait = 1'b0;
						if (ch == CH_LF) begin
							store_line(pos - 1 - run_len, run_len + 2, run_len, END_CRLF, r);
							consumed = 1'b1;
						end else begin
							store_line(pos - 1 - run_len, run_len + 1, run_len, END_CR, r);
						end
						run_len = 0;
					end
					if (!consumed) begin
						if (ch == CH_LF) begin
							store_line(pos - run_len, run_len + 1, run_len, END_LF, r);
							run_len = 0;
						end else if (ch == CH_CR) begin
							cr_wait = 1'b1;
						end else begin
							run_len++;
						end
					end
				end
			end
			OP_END: begin
				if (cr_wait) begin
					store_line(n_bytes - 1 - run_len, run_len + 1, run_len, END_CR, r);
				end else if (run_len > 0) begin
					store_line(n_bytes - run_len, run_len, run_len, END_NONE, r);
				end
				cr_wait = 1'b0;
				run_len = 0;
			end
			OP_FIND: begin
				if (n_lines > 0) begin
					lo = 0;
					hi = n_lines - 1;
					while (lo < hi) begin
						mid = lo + (hi - lo + 1) / 2;
						if (tbl_start[mid] <= q)
							lo = mid;
						else
							hi = mid - 1;
					end
					if (q >= tbl_start[lo] &&
							int'(q) < int'(tbl_start[lo]) + int'(tbl_len[lo])) begin
						r.found       = 1'b1;
						r.line_number = lo[LINE_AW-1:0];
						r.line_start  = tbl_start[lo];
						r.rel         = q - tbl_start[lo];
						r.line_length = tbl_len[lo];
						r.text_length = tbl_text[lo];
						r.kind        = tbl_kind[lo];
					end
				end
			end
			default: begin
				n_lines = 0;
				n_bytes = 0;
				run_len = 0;
				cr_wait = 1'b0;
				dropped = 1'b0;
			end
		endcase
		r.line_count = n_lines[LCNT_W-1:0];
		r.char_count = n_bytes[CHAR_W-1:0];
		r.overflow   = dropped;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Request generation
	// ------------------------------------------------------------------

	task automatic add(input op_t o, input logic [7:0] c, input logic [OFF_W-1:0] q);
		text_req_t t;
		t.op       = o;
		t.ch       = c;
		t.q        = q;
		t.idle_pct = gen_idle;
		t.drain    = gen_drain;
		gen_drain  = 1'b0;
		request_queue.push_back(t);
		if (o == OP_BYTE)
			gen_bytes++;
		else if (o == OP_CLEAR)
			gen_bytes = 0;
	endtask

	// Any byte that is not a line ending.
	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while (b == CH_LF || b == CH_CR);
		return b;
	endfunction

	// Offset aimed mostly at text already sent, sometimes anywhere.
	function automatic logic [OFF_W-1:0] aim_offset();
		if ($urandom_range(4) == 0 || gen_bytes + 2 > 65535)
			return OFF_W'($urandom_range(65535));
		return OFF_W'($urandom_range(gen_bytes + 2, 0));
	endfunction

	// A run of lines with random content, each ended by LF, CR, CRLF or nothing, then look-ups into it.
	task automatic text_block();
		int nl;
		int len;
		if ($urandom_range(9) < 3)
			add(OP_CLEAR, '0, '0);
		nl = $urandom_range(6, 1);
		repeat (nl) begin
			len = $urandom_range(10);
			repeat (len)
				add(OP_BYTE, plain_byte(), OFF_W'($urandom_range(65535)));
			case ($urandom_range(3))
				0: add(OP_BYTE, CH_LF, '0);
				1: add(OP_BYTE, CH_CR, '0);
				2: begin
					add(OP_BYTE, CH_CR, '0);
					add(OP_BYTE, CH_LF, '0);
				end
				default: ;
			endcase
		end
		if ($urandom_range(1))
			add(OP_END, 8'($urandom_range(255)), OFF_W'($urandom_range(65535)));
		repeat ($urandom_range(4, 1))
			add(OP_FIND, 8'($urandom_range(255)), aim_offset());
	endtask

	// Unstructured traffic: any op, any byte, any offset.
	task automatic noise_item();
		int pick;
		pick = $urandom_range(99);
		if (pick < 60)
			add(OP_BYTE, ($urandom_range(3) == 0) ? ($urandom_range(1) ? CH_LF : CH_CR)
					: 8'($urandom_range(255)), OFF_W'($urandom_range(65535)));
		else if (pick < 80)
			add(OP_FIND, 8'($urandom_range(255)), OFF_W'($urandom_range(65535)));
		else if (pick < 92)
			add(OP_END, 8'($urandom_range(255)), OFF_W'($urandom_range(65535)));
		else
			add(OP_CLEAR, 8'($urandom_range(255)), OFF_W'($urandom_range(65535)));
	endtask

	task automatic random_phase(input int count, input int idle_pct);
		int base;
		base      = request_queue.size();
		gen_idle  = idle_pct;
		gen_drain = 1'b1;
		while (request_queue.size() - base < count) begin
			if ($urandom_range(99) < 70)
				text_block();
			else
				noise_item();
			// Now and then hold the next request until the block has gone quiet.
			if ($urandom_range(99) == 0)
				gen_drain = 1'b1;
		end
	endtask

	// Clear, send a long run of bare line endings, then look-ups and an end of text.
	task automatic limit_phase();
		gen_drain = 1'b1;
		add(OP_CLEAR, '0, '0);
		// A CR closes its line at the next byte or end of text; an LF closes one unless it follows a CR, forming CRLF.
		repeat (MAX_LINES + 6) begin
			if ($urandom_range(1) == 0)
				add(OP_BYTE, CH_LF, '0);
			else
				add(OP_BYTE, CH_CR, '0);
		end
		add(OP_FIND, '0, '0);
		repeat (8)
			add(OP_FIND, '0, aim_offset());
		add(OP_FIND, '0, 16'hFFFF);
		add(OP_END, '0, '0);
		add(OP_CLEAR, '0, '0);
	endtask

	// ------------------------------------------------------------------
	// Driver: present one request at a time, hold it while busy
	// ------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start        <= 1'b0;
			op           <= OP_BYTE;
			text_byte    <= '0;
			query_offset <= '0;
		end else begin : drive
			bit go;
			bit quiet;
			go = 1'b0;
			// A request went in at this edge: work out what it must produce.
			if (start && !busy) begin
				awaited_results.push_back(predict_request(in_flight.op, in_flight.ch,
						in_flight.q));
				owed++;
			end
			// A result is taken at this edge.
			if (done)
				owed--;
			quiet = (owed == 0);
			if (!(start && busy) && request_queue.size() > 0) begin
				if ($urandom_range(99) >= request_queue[0].idle_pct &&
						(!request_queue[0].drain || quiet))
					go = 1'b1;
			end
			if (go) begin
				in_flight     = request_queue.pop_front();
				start        <= 1'b1;
				op           <= in_flight.op;
				text_byte    <= in_flight.ch;
				query_offset <= in_flight.q;
			end else if (!(start && busy)) begin
				start <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: every strobe is matched against the oldest prediction
	// ------------------------------------------------------------------

	task automatic check_field(input string name, input logic [16:0] want,
			input logic [16:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			failures++;
		end
	endtask

	always @(posedge clk) begin : monitor
		index_result_t want;
		if (arst_n && done) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: result with nothing awaited, expected none got line_count %0h",
						$time, line_count);
				failures++;
			end else begin
				want = awaited_results.pop_front();
				check_field("line_done", want.line_done, line_done);
				check_field("found", want.found, found);
				check_field("line_number", want.line_number, line_number);
				check_field("line_start", want.line_start, line_start);
				check_field("relative_offset", want.rel, relative_offset);
				check_field("line_length", want.line_length, line_length);
				check_field("text_length", want.text_length, text_length);
				check_field("ending_kind", want.kind, ending_kind);
				check_field("line_count", want.line_count, line_count);
				check_field("char_count", want.char_count, char_count);
				check_field("overflow", want.overflow, overflow);
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: give up when nothing moves for too long
	// ------------------------------------------------------------------

	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (start && !busy) || done)
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("text_line_indexer_top: mismatch");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------

	initial begin : stimulus
		// Sender idles lightly while the directed requests go through.
		gen_idle  = 19;
		gen_drain = 1'b1;
		add(OP_FIND, '0, '0);             // look-up with an empty table
		add(OP_END, '0, '0);              // end of text with nothing pending
		add(OP_BYTE, "a", '0);
		add(OP_BYTE, CH_LF, '0);          // plain LF line
		add(OP_BYTE, "b", '0);
		add(OP_BYTE, CH_CR, '0);
		add(OP_BYTE, "c", '0);            // CR closed by a non-LF byte
		add(OP_BYTE, CH_CR, '0);
		add(OP_BYTE, CH_LF, '0);          // CRLF pair
		add(OP_BYTE, CH_CR, '0);
		add(OP_BYTE, CH_CR, '0);          // empty CR line, new CR pending
		add(OP_END, 8'hFF, 16'hFFFF);     // flush the pending CR
		add(OP_BYTE, 8'hFF, 16'hFFFF);
		add(OP_BYTE, 8'h00, '0);
		add(OP_END, '0, '0);              // flush an unterminated line
		add(OP_BYTE, "z", '0);            // text continues after the end
		add(OP_FIND, '0, 16'd0);
		add(OP_FIND, '0, 16'd5);          // inside the CRLF line
		add(OP_FIND, '0, 16'd11);         // unfinished line is never found
		add(OP_FIND, '0, 16'hFFFF);       // past the last line
		add(OP_BYTE, CH_LF, '0);
		add(OP_FIND, '0, 16'd12);
		add(OP_CLEAR, 8'hFF, 16'hFFFF);
		add(OP_FIND, '0, '0);             // nothing left after a clear
		add(OP_END, '0, '0);

		random_phase(150, 19);
		random_phase(150, 78);
		random_phase(150, 0);
		limit_phase();

		// Hold reset, then release it once for the whole run.
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: every request sent and every awaited result seen.
		while (request_queue.size() != 0 || start || awaited_results.size() != 0)
			@(posedge clk);
		repeat (END_IDLE) @(posedge clk);

		if (failures == 0)
			$display("text_line_indexer_top: match");
		else
			$display("text_line_indexer_top: mismatch");
		$finish;
	end

endmodule

@@ files.f @@
hdl/tli_pkg.sv
hdl/tli_line_table.sv
hdl/tli_scanner.sv
hdl/tli_search.sv
hdl/text_line_indexer_top.sv
tb/text_line_indexer_top_test.sv
